[rtl/sesch_pkg.sv]
// Shared types and constants for the SCAN elevator scheduler.
// No dependencies; every module of the block imports this package.
package sesch_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYL_BITS    = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Item opcodes
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_ADD   = 2'd0;
    localparam t_opcode OP_SERVE = 2'd1;
    localparam t_opcode OP_HEAD  = 2'd2;
    localparam t_opcode OP_DIR   = 2'd3;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Best pick so far, handed from cell to cell
    typedef struct packed {
        logic                found;
        logic [CYL_BITS-1:0] value;
        logic [IDX_W-1:0]    idx;
    } t_cand;

    // Lowest free slot so far, handed from cell to cell
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_free;

    // Slot write / clear broadcast from the controller
    typedef struct packed {
        logic                wr;
        logic                clr;
        logic [IDX_W-1:0]    idx;
        logic [CYL_BITS-1:0] value;
    } t_cell_ctl;

    // Sweep state broadcast to every cell
    typedef struct packed {
        logic                dir;
        logic [CYL_BITS-1:0] head;
    } t_scan_ctl;

endpackage

[rtl/sesch_cell.sv]
// One slot of the request table plus its stage of the search chain.
// Depends on sesch_pkg for the chain and control structs.
module sesch_cell import sesch_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cell_ctl        i_ctl,
    input  t_scan_ctl        i_scan,
    input  t_cand            i_cand,
    input  t_free            i_free,
    output t_cand            o_cand,
    output t_free            o_free
);

    logic                r_valid;
    logic [CYL_BITS-1:0] r_value;
    t_cand               r_cand;
    t_free               r_free;
    t_cand               n_cand;
    t_free               n_free;
    logic                hit;
    logic                in_dir;
    logic                better;

    // Merge this slot into the candidates coming from the left neighbor
    always_comb begin
        hit    = (i_ctl.idx == i_idx);
        in_dir = i_scan.dir ? (r_value >= i_scan.head) : (r_value <= i_scan.head);
        better = i_scan.dir ? (r_value < i_cand.value) : (r_value > i_cand.value);
        n_cand = i_cand;
        if (r_valid && in_dir && (!i_cand.found || better)) begin
            n_cand.found = 1'b1;
            n_cand.value = r_value;
            n_cand.idx   = i_idx;
        end
        n_free = i_free;
        if (!i_free.found && !r_valid) begin
            n_free.found = 1'b1;
            n_free.idx   = i_idx;
        end
    end

    // Hold slot state and advance the chain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cand  <= '0;
            r_free  <= '0;
        end else begin
            if (i_ctl.wr && hit) begin
                r_valid <= 1'b1;
            end else if (i_ctl.clr && hit) begin
                r_valid <= 1'b0;
            end
            r_cand <= n_cand;
            r_free <= n_free;
        end
    end

    // Slot payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && hit) begin
            r_value <= i_ctl.value;
        end
    end

    assign o_cand = r_cand;
    assign o_free = r_free;

endmodule

[rtl/sesch_ctrl.sv]
// Sequencer for the scheduler: takes items, times the chain scans, drives
// slot writes and clears, and holds the result register. Uses sesch_pkg.
module sesch_ctrl import sesch_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_cylinder,
    input  logic        i_new_direction,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_served_cylinder,
    output logic        o_sweep_direction,
    output logic [4:0]  o_pending_count,
    input  t_cand       i_cand,
    input  t_free       i_free,
    output t_cell_ctl   o_ctl,
    output t_scan_ctl   o_scan
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state              r_state, n_state;
    t_opcode             r_op, n_op;
    logic [CYL_BITS-1:0] r_cyl, n_cyl;
    logic [CYL_BITS-1:0] r_head, n_head;
    logic                r_dir, n_dir;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_flip, n_flip;
    t_status             r_status, n_status;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_o_status, n_o_status;
    logic [15:0]         r_o_served, n_o_served;
    logic                r_o_dir, n_o_dir;
    logic [4:0]          r_o_count, n_o_count;
    t_cell_ctl           ctl;

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_cyl       = r_cyl;
        n_head      = r_head;
        n_dir       = r_dir;
        n_count     = r_count;
        n_cnt       = r_cnt;
        n_flip      = r_flip;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_served  = r_o_served;
        n_o_dir     = r_o_dir;
        n_o_count   = r_o_count;
        ctl         = '0;

        // drop the result beat once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_opcode;
                    n_cyl    = CYL_BITS'(i_cylinder);
                    n_status = ST_OK;
                    n_cnt    = '0;
                    n_flip   = 1'b0;
                    case (i_opcode)
                        OP_ADD: begin
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_SERVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_HEAD: begin
                            n_head  = CYL_BITS'(i_cylinder);
                            n_state = S_DONE;
                        end
                        OP_DIR: begin
                            n_dir   = i_new_direction;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_cnt == CNT_W'(QUEUE_DEPTH)) begin
                    // chain has settled: act on the last cell's candidates
                    if (r_op == OP_ADD) begin
                        ctl.wr    = 1'b1;
                        ctl.idx   = i_free.idx;
                        ctl.value = r_cyl;
                        n_count   = r_count + 1'b1;
                        n_state   = S_DONE;
                    end else if (i_cand.found) begin
                        ctl.clr = 1'b1;
                        ctl.idx = i_cand.idx;
                        n_head  = i_cand.value;
                        n_count = r_count - 1'b1;
                        n_state = S_DONE;
                    end else if (!r_flip) begin
                        // nothing ahead: reverse once and rescan
                        n_dir  = ~r_dir;
                        n_flip = 1'b1;
                        n_cnt  = '0;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_served  = 16'(r_head);
                    n_o_dir     = r_dir;
                    n_o_count   = 5'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_dir       <= 1'b0;
            r_count     <= '0;
            r_cnt       <= '0;
            r_flip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_dir       <= n_dir;
            r_count     <= n_count;
            r_cnt       <= n_cnt;
            r_flip      <= n_flip;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_cyl      <= n_cyl;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_served <= n_o_served;
        r_o_dir    <= n_o_dir;
        r_o_count  <= n_o_count;
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_o_status;
    assign o_served_cylinder = r_o_served;
    assign o_sweep_direction = r_o_dir;
    assign o_pending_count   = r_o_count;
    assign o_ctl             = ctl;
    assign o_scan.dir        = r_dir;
    assign o_scan.head       = r_head;

    // Pending count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("pending count beyond table depth");

    // Never write a slot into a full table
    a_wr_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.wr |-> (r_count < CNT_W'(QUEUE_DEPTH)))
        else $error("slot write with full table");

    // Write and clear are exclusive
    a_wr_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.wr && ctl.clr))
        else $error("slot write and clear together");

    // A clear lowers the count by exactly one
    a_clr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.clr |=> (r_count == $past(r_count) - 1'b1))
        else $error("count not decremented on clear");

endmodule

[rtl/scan_elevator_scheduler.sv]
// SCAN elevator scheduler top level: a row of slot cells plus the sequencer.
// Set head, set direction, add to a full table and serve of an empty table go from
// accept straight to the result beat; add and serve first scan the search chain,
// and serve scans it a second time when the sweep reverses. The search
// chain, one cell a cycle, paces the scans; one item is in work at a time.
// Synchronous active-low reset empties the table, head 0, direction down.
module scan_elevator_scheduler import sesch_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_cylinder,
    input  logic        i_new_direction,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_served_cylinder,
    output logic        o_sweep_direction,
    output logic [4:0]  o_pending_count
);

    t_cand     cand_chain [QUEUE_DEPTH+1];
    t_free     free_chain [QUEUE_DEPTH+1];
    t_cell_ctl cell_ctl;
    t_scan_ctl scan_ctl;

    // Chain starts with no pick and no free slot
    assign cand_chain[0] = '0;
    assign free_chain[0] = '0;

    // Row of slot cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        sesch_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (cell_ctl),
            .i_scan  (scan_ctl),
            .i_cand  (cand_chain[g]),
            .i_free  (free_chain[g]),
            .o_cand  (cand_chain[g+1]),
            .o_free  (free_chain[g+1])
        );
    end

    // Sequencer and result register
    sesch_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_cylinder        (i_cylinder),
        .i_new_direction   (i_new_direction),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_served_cylinder (o_served_cylinder),
        .o_sweep_direction (o_sweep_direction),
        .o_pending_count   (o_pending_count),
        .i_cand            (cand_chain[QUEUE_DEPTH]),
        .i_free            (free_chain[QUEUE_DEPTH]),
        .o_ctl             (cell_ctl),
        .o_scan            (scan_ctl)
    );

endmodule

[sim/tb_top.sv]
// Self-checking bench for scan_elevator_scheduler: a directed table, then random op streams.
// Results are checked beat by beat against a typed row's want or an in-bench SCAN predictor.
// Depends on sesch_pkg (opcodes, status codes, table depth) and the RTL top only.
module tb_top;
    import sesch_pkg::*;

    localparam int          RAND_ITEMS   = 1900;
    localparam int unsigned CYCLE_LIMIT  = 700000;
    localparam int          DRAIN_CYCLES = 80;

    // One result beat as the block presents it
    typedef struct packed {
        t_status     status;
        logic [15:0] served;
        logic        dir;
        logic [4:0]  count;
    } t_reply;

    // One row of the directed table; want is used only when typed is set
    typedef struct {
        t_opcode     op;
        logic [15:0] cyl;
        logic        nd;
        bit          typed;
        t_reply      want;
    } t_stim_row;

    localparam t_reply UNTYPED = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [1:0]  in_opcode = OP_DIR;
    logic [15:0] in_cylinder = '0;
    logic        in_new_dir = 1'b0;
    logic        out_stall = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [15:0] o_served_cylinder;
    logic        o_sweep_direction;
    logic [4:0]  o_pending_count;

    // Predictor state: shadow of the request table, head and sweep direction
    logic [CYL_BITS-1:0] cyl_store [QUEUE_DEPTH];
    bit                  slot_used [QUEUE_DEPTH];
    logic [CYL_BITS-1:0] head_pos = '0;
    logic                sweep_up = 1'b0;

    t_reply      reply_q [$];
    t_stim_row   rows [$];
    int          fail_cnt = 0;
    int          burst_left = 0;
    int unsigned cycle_cnt = 0;
    int          rx_mode = 0;
    int          rx_mode_left = 0;

    scan_elevator_scheduler dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (in_opcode),
        .i_cylinder        (in_cylinder),
        .i_new_direction   (in_new_dir),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_status          (o_status),
        .o_served_cylinder (o_served_cylinder),
        .o_sweep_direction (o_sweep_direction),
        .o_pending_count   (o_pending_count)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pending_total();
        int n;
        n = 0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (slot_used[i]) n++;
        return n;
    endfunction

    // Best slot in one sweep direction, -1 when nothing lies that way
    function automatic int nearest_in_sweep(logic up);
        int best;
        best = -1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (!slot_used[i]) continue;
            if (!up) begin
                if (cyl_store[i] <= head_pos && (best < 0 || cyl_store[i] > cyl_store[best]))
                    best = i;
            end else begin
                if (cyl_store[i] >= head_pos && (best < 0 || cyl_store[i] < cyl_store[best]))
                    best = i;
            end
        end
        return best;
    endfunction

    // Apply one op to the shadow state and return the beat it should produce
    function automatic t_reply run_scheduler_op(t_opcode op, logic [15:0] cyl, logic nd);
        t_reply r;
        int     slot;
        int     pick;
        r.status = ST_OK;
        case (op)
            OP_ADD: begin
                slot = -1;
                for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
                    if (!slot_used[i]) slot = i;
                if (slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    cyl_store[slot] = cyl[CYL_BITS-1:0];
                    slot_used[slot] = 1'b1;
                end
            end
            OP_SERVE: begin
                if (pending_total() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pick = nearest_in_sweep(sweep_up);
                    // reverse once when nothing lies ahead
                    if (pick < 0) begin
                        sweep_up = ~sweep_up;
                        pick = nearest_in_sweep(sweep_up);
                    end
                    head_pos = cyl_store[pick];
                    slot_used[pick] = 1'b0;
                end
            end
            OP_HEAD: head_pos = cyl[CYL_BITS-1:0];
            default: sweep_up = nd;
        endcase
        r.served = head_pos;
        r.dir    = sweep_up;
        r.count  = 5'(pending_total());
        return r;
    endfunction

    // Drive one beat: idle first if the burst ran out, then hold until accepted
    task automatic send_beat(t_opcode op, logic [15:0] cyl, logic nd, bit typed, t_reply want);
        t_reply pred;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end else begin
            burst_left--;
        end
        in_valid    <= 1'b1;
        in_opcode   <= op;
        in_cylinder <= cyl;
        in_new_dir  <= nd;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        pred = run_scheduler_op(op, cyl, nd);
        reply_q.push_back(typed ? want : pred);
    endtask

    // Receiver stall: free-flowing, random, or long periodic stalls, mode by mode
    always @(posedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(50, 300);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 35);
            default: out_stall <= (cycle_cnt[4:0] < 5'd20);
        endcase
    end

    // Check each accepted result beat against the oldest expectation
    always @(posedge clk) begin
        t_reply exp_r;
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (reply_q.size() == 0) begin
                $display("%0t unexpected result beat: status %0d served %h",
                         $time, o_status, o_served_cylinder);
                fail_cnt++;
            end else begin
                exp_r = reply_q.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, exp_r.status, o_status);
                    fail_cnt++;
                end
                if (o_served_cylinder !== exp_r.served) begin
                    $display("%0t served_cylinder: expected %h actual %h",
                             $time, exp_r.served, o_served_cylinder);
                    fail_cnt++;
                end
                if (o_sweep_direction !== exp_r.dir) begin
                    $display("%0t sweep_direction: expected %0d actual %0d",
                             $time, exp_r.dir, o_sweep_direction);
                    fail_cnt++;
                end
                if (o_pending_count !== exp_r.count) begin
                    $display("%0t pending_count: expected %0d actual %0d",
                             $time, exp_r.count, o_pending_count);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, reply_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_opcode     op;
        logic [15:0] cyl;
        int          mode;
        int          pick;
        int          add_th;
        int          serve_th;

        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            cyl_store[i] = '0;
            slot_used[i] = 1'b0;
        end

        // Directed table: empty serve, head/direction extremes, fill to full,
        // equal head, duplicate values, and a reversal from down to up
        rows.push_back('{OP_SERVE, 16'h0000, 1'b0, 1'b1, '{ST_EMPTY, 16'h0000, 1'b0, 5'd0}});
        rows.push_back('{OP_HEAD,  16'hFFFF, 1'b1, 1'b1, '{ST_OK, 16'hFFFF, 1'b0, 5'd0}});
        rows.push_back('{OP_DIR,   16'h0000, 1'b1, 1'b1, '{ST_OK, 16'hFFFF, 1'b1, 5'd0}});
        rows.push_back('{OP_DIR,   16'hFFFF, 1'b0, 1'b1, '{ST_OK, 16'hFFFF, 1'b0, 5'd0}});
        rows.push_back('{OP_ADD,   16'h0000, 1'b1, 1'b1, '{ST_OK, 16'hFFFF, 1'b0, 5'd1}});
        rows.push_back('{OP_ADD,   16'hFFFF, 1'b0, 1'b1, '{ST_OK, 16'hFFFF, 1'b0, 5'd2}});
        rows.push_back('{OP_ADD,   16'h8000, 1'b1, 1'b1, '{ST_OK, 16'hFFFF, 1'b0, 5'd3}});
        rows.push_back('{OP_ADD,   16'h8000, 1'b0, 1'b1, '{ST_OK, 16'hFFFF, 1'b0, 5'd4}});
        rows.push_back('{OP_ADD,   16'h0001, 1'b0, 1'b0, UNTYPED});
        rows.push_back('{OP_ADD,   16'h7FFF, 1'b1, 1'b0, UNTYPED});
        rows.push_back('{OP_ADD,   16'h5555, 1'b0, 1'b0, UNTYPED});
        rows.push_back('{OP_ADD,   16'hAAAA, 1'b1, 1'b0, UNTYPED});
        rows.push_back('{OP_ADD,   16'h0100, 1'b0, 1'b0, UNTYPED});
        rows.push_back('{OP_ADD,   16'h00FF, 1'b1, 1'b0, UNTYPED});
        rows.push_back('{OP_ADD,   16'h1234, 1'b0, 1'b0, UNTYPED});
        rows.push_back('{OP_ADD,   16'hFEDC, 1'b1, 1'b0, UNTYPED});
        rows.push_back('{OP_ADD,   16'h8000, 1'b0, 1'b0, UNTYPED});
        rows.push_back('{OP_ADD,   16'h4000, 1'b1, 1'b0, UNTYPED});
        rows.push_back('{OP_ADD,   16'h0010, 1'b0, 1'b0, UNTYPED});
        rows.push_back('{OP_ADD,   16'hC000, 1'b1, 1'b0, UNTYPED});
        rows.push_back('{OP_ADD,   16'h3333, 1'b1, 1'b1, '{ST_FULL, 16'hFFFF, 1'b0, 5'd16}});
        rows.push_back('{OP_HEAD,  16'h8000, 1'b0, 1'b0, UNTYPED});
        rows.push_back('{OP_SERVE, 16'hFFFF, 1'b1, 1'b0, UNTYPED});
        rows.push_back('{OP_HEAD,  16'h0000, 1'b1, 1'b0, UNTYPED});
        rows.push_back('{OP_SERVE, 16'h0000, 1'b0, 1'b0, UNTYPED});
        rows.push_back('{OP_SERVE, 16'h5A5A, 1'b1, 1'b0, UNTYPED});

        // Hold reset, then release it once
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_beat(rows[i].op, rows[i].cyl, rows[i].nd, rows[i].typed, rows[i].want);

        // Random ops: fill, drain and mixed phases so the table swings full to empty
        mode = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 48 == 0) mode = $urandom_range(0, 2);
            case (mode)
                0:       begin add_th = 65; serve_th = 85; end
                1:       begin add_th = 25; serve_th = 85; end
                default: begin add_th = 45; serve_th = 80; end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < add_th)          op = OP_ADD;
            else if (pick < serve_th)   op = OP_SERVE;
            else if (pick < 92)         op = OP_HEAD;
            else                        op = OP_DIR;
            // Cluster values to force ties and head-equal picks
            case ($urandom_range(0, 9))
                0, 1, 2: cyl = 16'($urandom_range(0, 15));
                3:       cyl = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                4, 5:    cyl = head_pos + 16'($urandom_range(0, 6)) - 16'd3;
                default: cyl = 16'($urandom());
            endcase
            send_beat(op, cyl, 1'($urandom_range(0, 1)), 1'b0, UNTYPED);
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then watch for stray beats
        while (reply_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
